// ===== design/act_pkg.sv =====
`default_nettype none
package act_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int DATA_W      = 32;
  localparam int KIND_W      = 2;
  localparam int DIV_W       = 8;
  localparam int PRE_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 8;

  localparam int MASK_BIT    = 16;
  localparam int MODE_SHIFT  = 17;
  localparam logic [1:0] MODE_FIELD = 2'h3;
  localparam logic [DIV_W-1:0] DIV_MAX = DIV_W'(128);

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK = 2'd0,
    KIND_VEC  = 2'd1,
    KIND_INIT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    TM_STOPPED  = 2'd0,
    TM_ONESHOT  = 2'd1,
    TM_PERIODIC = 2'd2
  } tmode_t;

  // vector word bits 18:17
  typedef enum logic [1:0] {
    SEL_ONESHOT  = 2'd0,
    SEL_PERIODIC = 2'd1,
    SEL_DEADLINE = 2'd2,
    SEL_RESERVED = 2'd3
  } sel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIVIDE = 1'd0,
    CFG_EVM    = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data;
  } item_t;

endpackage
`default_nettype wire

// ===== design/act_in_if.sv =====
`default_nettype none
interface act_in_if;
  import act_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] mode;
  logic [DATA_W-1:0] data;

  modport source (output valid, output mode, output data, input ready);
  modport sink   (input valid, input mode, input data, output ready);
endinterface
`default_nettype wire

// ===== design/act_out_if.sv =====
`default_nettype none
interface act_out_if;
  import act_pkg::*;

  logic              valid;
  logic              ready;
  logic              irq;
  logic              expired;
  logic [DATA_W-1:0] count_now;
  logic              running;

  modport source (output valid, output irq, output expired, output count_now,
                  output running, input ready);
  modport sink   (input valid, input irq, input expired, input count_now,
                  input running, output ready);
endinterface
`default_nettype wire

// ===== design/apic_countdown_timer_top.sv =====
// Countdown timer of a local interrupt controller.
// in_if carries one transaction per item: mode 0 is a tick, mode 1 writes the
// timer vector word (bits 18:17 pick one-shot, periodic or stop; bit 16 masks),
// mode 2 writes the initial count. out_if returns exactly one transaction per
// input transaction, in order: irq, expired, count_now and running after the item.
// The cfg port writes divide_value (index 0) and error_vector_masked (index 1)
// on any edge with cfg_we high; write it only while the block is idle.
// An accepted transaction waits in the input register; its result is held in the result register, which drives out_if.
// Throughput: one transaction per cycle while out_if takes results; the timer state
// is updated combinationally between the input register and the result register.
// A stalled out_if holds its result; the input register still takes one more
// transaction, then in_if.ready drops until the result is taken.
// Reset (rst_n low, synchronous) stops the timer, clears the counts and
// prescaler, masks the vector, sets divide_value to 1 and error_vector_masked
// to 1, and empties both registers.
`default_nettype none
module apic_countdown_timer_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  act_in_if.sink                             in_if,
  act_out_if.source                          out_if,
  input  wire logic                          cfg_we,
  input  wire logic [act_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [act_pkg::CFG_W-1:0]     cfg_wdata
);
  import act_pkg::*;

  item_t item;
  logic  item_valid;
  logic  take;

  // hold the accepted transaction until the core can retire it
  act_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .take       (take),
    .item       (item),
    .item_valid (item_valid)
  );

  // advance the timer state and register the result
  act_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_if     (out_if)
  );

endmodule
`default_nettype wire

// ===== design/act_in_stage.sv =====
`default_nettype none
module act_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  act_in_if.sink             in_if,
  input  wire logic          take,
  output act_pkg::item_t     item,
  output logic               item_valid
);
  import act_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // refill whenever the held transaction moves on or the slot is empty
  assign in_if.ready = !valid_r || take;
  assign load        = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.kind <= in_if.mode;
      item_r.data <= in_if.data;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule
`default_nettype wire

// ===== design/act_core.sv =====
`default_nettype none
module act_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [act_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [act_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          item_valid,
  input  wire act_pkg::item_t                item,
  output logic                               take,
  act_out_if.source                          out_if
);
  import act_pkg::*;

  // configuration
  logic [DIV_W-1:0]       divide_r;
  logic                   evm_r;

  // timer state
  logic [PRE_W-1:0]       pre_r, pre_nxt;
  tmode_t                 tmode_r, tmode_nxt;
  logic                   mask_r, mask_nxt;
  logic [COUNT_WIDTH-1:0] init_r, init_nxt;
  logic [COUNT_WIDTH-1:0] cur_r, cur_nxt;

  // result register
  logic                   ov_r;
  logic                   irq_r, irq_nxt;
  logic                   exp_r, exp_nxt;
  logic [DATA_W-1:0]      cnt_r;
  logic                   run_r;

  logic [DIV_W-1:0]              div_eff;
  logic [DIV_W-1:0]              pre_inc;
  logic [COUNT_WIDTH-1:0]        cur_dec;
  logic [COUNT_WIDTH+DATA_W-1:0] init_ext;
  logic [COUNT_WIDTH+DATA_W-1:0] cnt_ext;
  sel_t                          sel;

  assign take = item_valid && (!ov_r || out_if.ready);

  always_comb begin
    div_eff = divide_r;
    if (divide_r == '0) begin
      div_eff = DIV_W'(1);
    end else if (divide_r > DIV_MAX) begin
      div_eff = DIV_MAX;
    end
  end

  assign pre_inc  = DIV_W'(pre_r) + DIV_W'(1);
  assign cur_dec  = cur_r - COUNT_WIDTH'(1);
  assign init_ext = {{COUNT_WIDTH{1'b0}}, item.data};
  assign sel      = sel_t'(item.data[MODE_SHIFT +: 2] & MODE_FIELD);

  always_comb begin
    pre_nxt   = pre_r;
    tmode_nxt = tmode_r;
    mask_nxt  = mask_r;
    init_nxt  = init_r;
    cur_nxt   = cur_r;
    irq_nxt   = 1'b0;
    exp_nxt   = 1'b0;
    unique case (item.kind)
      KIND_TICK: begin
        if (tmode_r != TM_STOPPED) begin
          pre_nxt = pre_inc[PRE_W-1:0];
          if (pre_inc >= div_eff) begin
            pre_nxt = '0;
            if (cur_r != '0) begin
              cur_nxt = cur_dec;
            end
          end
          if (cur_nxt == '0) begin
            exp_nxt = 1'b1;
            irq_nxt = !mask_r && !evm_r;
            if (tmode_r == TM_PERIODIC) begin
              cur_nxt = init_r;
            end else begin
              tmode_nxt = TM_STOPPED;
            end
          end
        end
      end
      KIND_VEC: begin
        mask_nxt = item.data[MASK_BIT];
        unique case (sel)
          SEL_ONESHOT:  tmode_nxt = TM_ONESHOT;
          SEL_PERIODIC: tmode_nxt = TM_PERIODIC;
          default:      tmode_nxt = TM_STOPPED;
        endcase
        cur_nxt = init_r;
      end
      KIND_INIT: begin
        init_nxt = init_ext[COUNT_WIDTH-1:0];
        cur_nxt  = init_ext[COUNT_WIDTH-1:0];
      end
      default: begin
      end
    endcase
  end

  assign cnt_ext = {{DATA_W{1'b0}}, cur_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divide_r <= DIV_W'(1);
      evm_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DIVIDE: divide_r <= cfg_wdata;
        CFG_EVM:    evm_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r   <= '0;
      tmode_r <= TM_STOPPED;
      mask_r  <= 1'b1;
      init_r  <= '0;
      cur_r   <= '0;
    end else if (take) begin
      pre_r   <= pre_nxt;
      tmode_r <= tmode_nxt;
      mask_r  <= mask_nxt;
      init_r  <= init_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (take) begin
      ov_r <= 1'b1;
    end else if (out_if.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      irq_r <= irq_nxt;
      exp_r <= exp_nxt;
      cnt_r <= cnt_ext[DATA_W-1:0];
      run_r <= (tmode_nxt != TM_STOPPED);
    end
  end

  assign out_if.valid     = ov_r;
  assign out_if.irq       = irq_r;
  assign out_if.expired   = exp_r;
  assign out_if.count_now = cnt_r;
  assign out_if.running   = run_r;

endmodule
`default_nettype wire
